>>> hdl/lkp_pkg.sv
`timescale 1ns / 1ps

package lkp_pkg;

  // Request kinds carried in the input item
  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_BRIGHT  = 3'd1,
    KIND_REFRESH = 3'd2,
    KIND_SCAN    = 3'd3,
    KIND_KEY     = 3'd4
  } kind_e;

  // Configuration register indexes
  localparam logic CFG_OFF_COMMAND     = 1'b0;
  localparam logic CFG_BRIGHTNESS_BASE = 1'b1;

  // Register reset values
  localparam logic [7:0] OFF_COMMAND_RST     = 8'h80;
  localparam logic [7:0] BRIGHTNESS_BASE_RST = 8'h88;

  // Panel command bytes
  localparam logic [7:0] CMD_DATA_SET  = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
  localparam logic [7:0] CMD_READ_KEYS = 8'h42;

  // Highest brightness level
  localparam logic [7:0] MAX_LEVEL = 8'd8;

  // Slot and key byte counters cover up to eight bytes
  localparam int unsigned KEY_CNT_W = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] buffer_index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       read_slot;
    logic       frame_start;
    logic       frame_end;
    logic       key_event;
    logic [7:0] pressed_mask;
    logic [7:0] released_mask;
    logic       last;
  } out_item_t;

  // Requests from the sequencer to the key tracker
  typedef struct packed {
    logic       start;
    logic       sample;
    logic [7:0] value;
  } key_cmd_t;

  // Key change event back to the sequencer
  typedef struct packed {
    logic       fire;
    logic [7:0] pressed;
    logic [7:0] released;
  } key_evt_t;

endpackage

>>> hdl/led_key_panel_serial_controller.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  lkp_pkg::in_item_t
// out       output     out_valid_o / out_ready_i lkp_pkg::out_item_t
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A buffer write, or a key byte that emits no event, sends nothing; a key byte that
// emits an event sends one event transfer. Other requests give one transfer per cycle
// from the sequencer while the output is not stalled, and the buffer memory read port
// feeds one refresh byte per cycle on that condition too. A new item is taken once the
// sequencer is idle. Reset clears the buffer through per-entry valid bits, with no
// clearing pass. A stalled output holds the sequencer in place.

module led_key_panel_serial_controller #(
  parameter int unsigned BUFFER_BYTES = 16,
  parameter int unsigned KEY_BYTES    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lkp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lkp_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [AW-1:0] LastAddr = AW'(BUFFER_BYTES - 1);
  localparam logic [6:0] BufLimit = 7'(BUFFER_BYTES);
  localparam logic [lkp_pkg::KEY_CNT_W-1:0] LastSlot =
    lkp_pkg::KEY_CNT_W'(KEY_BYTES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BRIGHT = 3'd1;
  localparam logic [2:0] S_DSET   = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_DATA   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_SLOT   = 3'd6;
  localparam logic [2:0] S_EVENT  = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic [lkp_pkg::KEY_CNT_W-1:0] slot_q, slot_d;
  logic [7:0]                    byte_q, byte_d;
  logic [7:0]                    pr_q, pr_d;
  logic [7:0]                    rl_q, rl_d;
  logic [7:0]                    off_q, base_q;
  logic                          out_valid_q, out_valid_d;
  lkp_pkg::out_item_t            out_q, out_d;
  lkp_pkg::out_item_t            res;
  lkp_pkg::key_cmd_t             kcmd;
  lkp_pkg::key_evt_t             kevt;
  logic                          emit;
  logic                          can_load;
  logic                          in_range;
  logic                          mem_we;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [7:0]                    mem_rdata;
  logic [7:0]                    level;
  logic [7:0]                    bright_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= lkp_pkg::OFF_COMMAND_RST;
      base_q <= lkp_pkg::BRIGHTNESS_BASE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lkp_pkg::CFG_OFF_COMMAND) begin
        off_q <= cfg_data_i;
      end
      if (cfg_idx_i == lkp_pkg::CFG_BRIGHTNESS_BASE) begin
        base_q <= cfg_data_i;
      end
    end
  end

  // Saturate the level and form the brightness command
  assign level      = (in_data_i.value > lkp_pkg::MAX_LEVEL) ? lkp_pkg::MAX_LEVEL
                                                             : in_data_i.value;
  assign bright_cmd = (level == 8'd0) ? off_q : base_q + level - 8'd1;

  assign in_range   = {3'b000, in_data_i.buffer_index} < BufLimit;
  assign in_ready_o = (state_q == S_IDLE);
  assign emit       = (state_q != S_IDLE);
  assign can_load   = !out_valid_q || out_ready_i;

  lkp_buf_mem #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buf_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (AW'(in_data_i.buffer_index)),
    .wdata_i (in_data_i.value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lkp_key_trk #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key_trk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (kcmd),
    .evt_o  (kevt)
  );

  // Sequence the transfers of each request
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    slot_d       = slot_q;
    byte_d       = byte_q;
    pr_d         = pr_q;
    rl_d         = rl_q;
    res          = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q;
    kcmd         = '0;
    kcmd.value   = in_data_i.value;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.kind)
            lkp_pkg::KIND_WRITE: begin
              mem_we = in_range;
            end
            lkp_pkg::KIND_BRIGHT: begin
              byte_d  = bright_cmd;
              state_d = S_BRIGHT;
            end
            lkp_pkg::KIND_REFRESH: begin
              state_d = S_DSET;
            end
            lkp_pkg::KIND_SCAN: begin
              kcmd.start = 1'b1;
              state_d    = S_SCAN;
            end
            lkp_pkg::KIND_KEY: begin
              kcmd.sample = 1'b1;
              if (kevt.fire) begin
                pr_d    = kevt.pressed;
                rl_d    = kevt.released;
                state_d = S_EVENT;
              end
            end
            default: ;
          endcase
        end
      end
      S_BRIGHT: begin
        res.wire_byte   = byte_q;
        res.frame_start = 1'b1;
        res.frame_end   = 1'b1;
        res.last        = 1'b1;
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      S_DSET: begin
        res.wire_byte   = lkp_pkg::CMD_DATA_SET;
        res.frame_start = 1'b1;
        res.frame_end   = 1'b1;
        if (can_load) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        res.wire_byte   = lkp_pkg::CMD_ADDR_ZERO;
        res.frame_start = 1'b1;
        if (can_load) begin
          // Fetch the first buffer byte
          mem_re    = 1'b1;
          mem_raddr = '0;
          ptr_d     = '0;
          state_d   = S_DATA;
        end
      end
      S_DATA: begin
        res.wire_byte = mem_rdata;
        res.frame_end = (ptr_q == LastAddr);
        res.last      = (ptr_q == LastAddr);
        if (can_load) begin
          if (ptr_q == LastAddr) begin
            state_d = S_IDLE;
          end else begin
            // Prefetch the next byte while this one leaves
            ptr_d     = ptr_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = ptr_q + 1'b1;
          end
        end
      end
      S_SCAN: begin
        res.wire_byte   = lkp_pkg::CMD_READ_KEYS;
        res.frame_start = 1'b1;
        if (can_load) begin
          slot_d  = '0;
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        res.read_slot = 1'b1;
        res.frame_end = (slot_q == LastSlot);
        res.last      = (slot_q == LastSlot);
        if (can_load) begin
          if (slot_q == LastSlot) begin
            state_d = S_IDLE;
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end
      end
      S_EVENT: begin
        res.key_event     = 1'b1;
        res.pressed_mask  = pr_q;
        res.released_mask = rl_q;
        res.last          = 1'b1;
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: load a result when the slot is free, drop it on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit && can_load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    slot_q <= slot_d;
    byte_q <= byte_d;
    pr_q   <= pr_d;
    rl_q   <= rl_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A refresh always opens with the data set frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == lkp_pkg::KIND_REFRESH
      |=> state_q == S_DSET)
    else $error("refresh did not start with the data set frame");

  // Events carry no wire byte and no slot flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_event
      |-> out_data_o.wire_byte == 8'h00 && !out_data_o.read_slot && out_data_o.last)
    else $error("key event carries transfer fields");

  // Read slots never open a frame and send zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_slot
      |-> !out_data_o.frame_start && out_data_o.wire_byte == 8'h00)
    else $error("read slot opened a frame or sent data");

  // Only the data set frame closes without ending the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end && !out_data_o.last
      |-> out_data_o.wire_byte == lkp_pkg::CMD_DATA_SET)
    else $error("frame closed in the middle of a request");

endmodule

>>> hdl/lkp_buf_mem.sv
`timescale 1ns / 1ps

module lkp_buf_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  // Write the array, read through a registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track written entries; reset empties the buffer at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // Unwritten entries read as zero
  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

>>> hdl/lkp_key_trk.sv
`timescale 1ns / 1ps

module lkp_key_trk #(
  parameter int unsigned KEY_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkp_pkg::key_cmd_t cmd_i,
  output lkp_pkg::key_evt_t evt_o
);

  localparam logic [lkp_pkg::KEY_CNT_W-1:0] LastByte =
    lkp_pkg::KEY_CNT_W'(KEY_BYTES - 1);

  logic [7:0]                    acc_q, acc_d;
  logic [7:0]                    prev_q, prev_d;
  logic [lkp_pkg::KEY_CNT_W-1:0] cnt_q, cnt_d;
  logic                          open_q, open_d;
  logic [14:0]                   shifted;
  logic [7:0]                    acc_n;

  // Merge the sampled byte at its slot offset
  assign shifted = {7'b0, cmd_i.value} << cnt_q;
  assign acc_n   = acc_q | shifted[7:0];

  always_comb begin
    acc_d          = acc_q;
    prev_d         = prev_q;
    cnt_d          = cnt_q;
    open_d         = open_q;
    evt_o.fire     = 1'b0;
    evt_o.pressed  = acc_n & ~prev_q;
    evt_o.released = prev_q & ~acc_n;
    priority if (cmd_i.start) begin
      // Restart the scan from an empty word
      acc_d  = 8'h00;
      cnt_d  = '0;
      open_d = 1'b1;
    end else if (cmd_i.sample && open_q) begin
      acc_d = acc_n;
      if (cnt_q == LastByte) begin
        // Close the scan and report a change
        cnt_d  = '0;
        open_d = 1'b0;
        if (acc_n != prev_q) begin
          evt_o.fire = 1'b1;
          prev_d     = acc_n;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 8'h00;
      prev_q <= 8'h00;
      cnt_q  <= '0;
      open_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      open_q <= open_d;
    end
  end

endmodule

>>> tb/panel_tb_pkg.sv
`timescale 1ns / 1ps

package panel_tb_pkg;

  import lkp_pkg::*;

  localparam int unsigned PANEL_BYTES = 16;
  localparam int unsigned SCAN_BYTES  = 4;
  localparam int unsigned MAX_REPORTS = 40;

  class panel_scoreboard;

    // Mirror of the panel controller state
    logic [7:0]  seg_buffer [PANEL_BYTES];
    logic [7:0]  key_word;
    logic [7:0]  held_keys;
    int unsigned key_count;
    bit          scan_open;
    logic [7:0]  off_cmd;
    logic [7:0]  level_base;

    // Transfers and key events still owed by the block, oldest first
    out_item_t   awaited_results [$];
    int unsigned errors;

    function new();
      foreach (seg_buffer[i]) seg_buffer[i] = '0;
      key_word   = '0;
      held_keys  = '0;
      key_count  = 0;
      scan_open  = 1'b0;
      off_cmd    = OFF_COMMAND_RST;
      level_base = BRIGHTNESS_BASE_RST;
      errors     = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] data);
      if (idx == CFG_OFF_COMMAND) begin
        off_cmd = data;
      end else begin
        level_base = data;
      end
    endfunction

    function void push_expected(logic [7:0] wire_byte, logic rd, logic st, logic en,
                                logic ev, logic [7:0] pr, logic [7:0] rl, logic lst);
      out_item_t item;
      item.wire_byte     = wire_byte;
      item.read_slot     = rd;
      item.frame_start   = st;
      item.frame_end     = en;
      item.key_event     = ev;
      item.pressed_mask  = pr;
      item.released_mask = rl;
      item.last          = lst;
      awaited_results.push_back(item);
    endfunction

    // Work out what one accepted request sends over the panel link
    function void note_request(in_item_t req);
      logic [7:0]  level;
      logic [7:0]  cmd;
      logic [15:0] shifted;
      case (req.kind)
        KIND_WRITE: begin
          seg_buffer[req.buffer_index] = req.value;
        end
        KIND_BRIGHT: begin
          level = (req.value > MAX_LEVEL) ? MAX_LEVEL : req.value;
          cmd   = (level == 8'd0) ? off_cmd : level_base + level - 8'd1;
          push_expected(cmd, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 1'b1);
        end
        KIND_REFRESH: begin
          push_expected(CMD_DATA_SET, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
          push_expected(CMD_ADDR_ZERO, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
          for (int i = 0; i < PANEL_BYTES; i++) begin
            push_expected(seg_buffer[i], 1'b0, 1'b0, i == PANEL_BYTES - 1, 1'b0,
                          8'h00, 8'h00, i == PANEL_BYTES - 1);
          end
        end
        KIND_SCAN: begin
          key_word  = '0;
          key_count = 0;
          scan_open = 1'b1;
          push_expected(CMD_READ_KEYS, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
          for (int i = 0; i < SCAN_BYTES; i++) begin
            push_expected(8'h00, 1'b1, 1'b0, i == SCAN_BYTES - 1, 1'b0,
                          8'h00, 8'h00, i == SCAN_BYTES - 1);
          end
        end
        KIND_KEY: begin
          // Drop key bytes that arrive with no scan open
          if (scan_open) begin
            shifted  = {8'h00, req.value} << key_count;
            key_word = key_word | shifted[7:0];
            key_count++;
            if (key_count == SCAN_BYTES) begin
              key_count = 0;
              scan_open = 1'b0;
              if (key_word != held_keys) begin
                push_expected(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, key_word & ~held_keys,
                              held_keys & ~key_word, 1'b1);
                held_keys = key_word;
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one output transfer with the oldest expectation
    task check_transfer(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.wire_byte !== want.wire_byte)
        report_mismatch($sformatf("wire_byte %h, want %h", got.wire_byte, want.wire_byte));
      if (got.read_slot !== want.read_slot)
        report_mismatch($sformatf("read_slot %b, want %b", got.read_slot, want.read_slot));
      if (got.frame_start !== want.frame_start)
        report_mismatch($sformatf("frame_start %b, want %b", got.frame_start,
                                  want.frame_start));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
      if (got.key_event !== want.key_event)
        report_mismatch($sformatf("key_event %b, want %b", got.key_event, want.key_event));
      if (got.pressed_mask !== want.pressed_mask)
        report_mismatch($sformatf("pressed_mask %h, want %h", got.pressed_mask,
                                  want.pressed_mask));
      if (got.released_mask !== want.released_mask)
        report_mismatch($sformatf("released_mask %h, want %h", got.released_mask,
                                  want.released_mask));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask

  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import lkp_pkg::*;
  import panel_tb_pkg::*;

  // Worst case: every request a refresh, every transfer a long stall
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned PHASES        = 5;

  // Request kinds the block does not decode
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CFG_OFF_COMMAND;
  logic [7:0] cfg_data_i  = 8'h00;

  panel_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned counted    = 0;
  int unsigned send_calm  = 0;
  int unsigned take_calm  = 0;
  int unsigned stall_left = 0;
  logic [7:0]  last_keys [SCAN_BYTES];

  led_key_panel_serial_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 2) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Take results with random stalls and check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_transfer(out_data_o);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= (stall_left == 0);
    end else begin
      stall_left = pick_gap(take_calm);
      out_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request and hold it until the transfer happens
  task automatic send_request(input logic [2:0] kind, input logic [3:0] idx,
                              input logic [7:0] value);
    in_item_t    req;
    int unsigned gap;
    req.kind         = kind;
    req.buffer_index = idx;
    req.value        = value;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (!(kind > KIND_KEY || (kind == KIND_KEY && !sb.scan_open))) counted++;
    sb.note_request(req);
  endtask

  task automatic write_registers(input logic [7:0] off_value, input logic [7:0] base_value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OFF_COMMAND;
    cfg_data_i <= off_value;
    @(posedge clk_i);
    sb.set_register(CFG_OFF_COMMAND, off_value);
    cfg_idx_i  <= CFG_BRIGHTNESS_BASE;
    cfg_data_i <= base_value;
    @(posedge clk_i);
    sb.set_register(CFG_BRIGHTNESS_BASE, base_value);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait for every owed result, then let a silent key byte finish
  task automatic drain;
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_other;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) begin
      send_request(KIND_WRITE, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end else if (roll < 85) begin
      send_request(KIND_BRIGHT, 4'($urandom_range(15)),
                   8'(($urandom_range(99) < 70) ? $urandom_range(9) : $urandom_range(255)));
    end else begin
      send_request(KIND_REFRESH, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end
  endtask

  // Scan followed by its key bytes; sometimes interleaved, sometimes cut short
  task automatic run_scan;
    int unsigned mode;
    logic [7:0]  key;
    mode = $urandom_range(99);
    send_request(KIND_SCAN, 4'($urandom_range(15)), 8'($urandom_range(255)));
    for (int i = 0; i < SCAN_BYTES; i++) begin
      if ($urandom_range(99) < 4) return;
      if ($urandom_range(99) < 15) run_other();
      if (mode < 40) key = 8'($urandom_range(255));
      else if (mode < 65) key = last_keys[i];
      else if (mode < 80) key = 8'h00;
      else key = 8'h01 << $urandom_range(7);
      last_keys[i] = key;
      send_request(KIND_KEY, 4'($urandom_range(15)), key);
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned roll;
    counted = 0;
    while (counted < budget) begin
      roll = $urandom_range(99);
      if (roll < 35) run_scan();
      else if (roll < 90) run_other();
      else if (roll < 95) send_request(KIND_KEY, 4'($urandom_range(15)),
                                       8'($urandom_range(255)));
      else send_request(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                        4'($urandom_range(15)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [7:0] off_set  [PHASES];
    logic [7:0] base_set [PHASES];
    foreach (last_keys[i]) last_keys[i] = 8'h00;
    off_set  = '{8'h00, 8'hFF, 8'($urandom_range(255)), OFF_COMMAND_RST,
                 8'($urandom_range(255))};
    base_set = '{8'h00, 8'hFF, 8'($urandom_range(255)), BRIGHTNESS_BASE_RST, 8'hF9};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Buffer must read back as zero after reset
    send_request(KIND_REFRESH, 4'd0, 8'h00);
    send_request(KIND_WRITE, 4'd0, 8'hFF);
    send_request(KIND_WRITE, 4'd15, 8'h81);
    send_request(KIND_REFRESH, 4'd15, 8'hFF);
    // Off command, lowest and highest level
    send_request(KIND_BRIGHT, 4'd0, 8'd0);
    send_request(KIND_BRIGHT, 4'd0, 8'd1);
    send_request(KIND_BRIGHT, 4'd0, MAX_LEVEL);
    // Key byte with no scan open, and an undecoded kind
    send_request(KIND_KEY, 4'd0, 8'hFF);
    send_request(KIND_SPARE_HI, 4'd15, 8'hFF);
    // All keys pressed: released mask is zero
    send_request(KIND_SCAN, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'hFF);
    send_request(KIND_KEY, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'h00);
    // Same word again with a saturating brightness inside the scan: no event
    send_request(KIND_SCAN, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'hFF);
    send_request(KIND_BRIGHT, 4'd0, 8'hFF);
    send_request(KIND_KEY, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'h00);
    // Restart mid-scan, then shifted single bits: pressed mask is zero
    send_request(KIND_SCAN, 4'd0, 8'h00);
    send_request(KIND_KEY, 4'd0, 8'h80);
    send_request(KIND_SCAN, 4'd0, 8'h00);
    for (int i = 0; i < SCAN_BYTES; i++) send_request(KIND_KEY, 4'd0, 8'h01);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_registers(off_set[p], base_set[p]);
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
